>>> rtl/sbt_pkg.sv
`default_nettype none

package sbt_pkg;

  localparam int unsigned LINE_BITS   = 16;
  localparam int unsigned COLUMN_BITS = 16;
  localparam int unsigned LENGTH_BITS = 8;
  localparam int unsigned KIND_BITS   = 3;
  localparam int unsigned BYTE_BITS   = 8;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_BITS   = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_BITS   = $clog2(FIFO_DEPTH + 1);

  localparam logic [BYTE_BITS-1:0] CHAR_SPACE   = 8'h20;
  localparam logic [BYTE_BITS-1:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [BYTE_BITS-1:0] CHAR_EQUALS  = 8'h3D;
  localparam logic [BYTE_BITS-1:0] CHAR_SEMI    = 8'h3B;
  localparam logic [BYTE_BITS-1:0] CHAR_L       = 8'h6C;
  localparam logic [BYTE_BITS-1:0] CHAR_E       = 8'h65;
  localparam logic [BYTE_BITS-1:0] CHAR_T       = 8'h74;
  localparam logic [BYTE_BITS-1:0] CHAR_F       = 8'h66;
  localparam logic [BYTE_BITS-1:0] CHAR_N       = 8'h6E;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_IDENT = 2'd1,
    MODE_NUM   = 2'd2,
    MODE_HALT  = 2'd3
  } mode_e;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_IDENT = 3'd0,
    KIND_NUM   = 3'd1,
    KIND_EQ    = 3'd2,
    KIND_SEMI  = 3'd3,
    KIND_END   = 3'd4,
    KIND_LET   = 3'd5,
    KIND_FN    = 3'd6,
    KIND_STRAY = 3'd7
  } kind_e;

  typedef enum logic [2:0] {
    KW_NONE = 3'd0,
    KW_L    = 3'd1,
    KW_LE   = 3'd2,
    KW_LET  = 3'd3,
    KW_F    = 3'd4,
    KW_FN   = 3'd5,
    KW_MISS = 3'd6
  } kw_e;

  typedef struct packed {
    kind_e                  kind;
    logic [LINE_BITS-1:0]   line;
    logic [COLUMN_BITS-1:0] column;
    logic [LENGTH_BITS-1:0] length;
    logic [BYTE_BITS-1:0]   stray;
    logic                   last;
  } record_t;

  typedef struct packed {
    logic [1:0] num;
    record_t    first;
    record_t    second;
  } emit_t;

  function automatic logic is_letter(input logic [BYTE_BITS-1:0] b);
    return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
  endfunction

  function automatic logic is_digit(input logic [BYTE_BITS-1:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic kw_e next_progress(input kw_e p, input logic [BYTE_BITS-1:0] b);
    kw_e r;
    r = KW_MISS;
    unique case (p)
      KW_NONE: begin
        if (b == CHAR_L) begin
          r = KW_L;
        end else if (b == CHAR_F) begin
          r = KW_F;
        end
      end
      KW_L:    if (b == CHAR_E) r = KW_LE;
      KW_LE:   if (b == CHAR_T) r = KW_LET;
      KW_F:    if (b == CHAR_N) r = KW_FN;
      default: r = KW_MISS;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/sbt_core.sv
`default_nettype none

module sbt_core import sbt_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 accept_i,
  input  wire logic                 action_i,
  input  wire logic [BYTE_BITS-1:0] source_byte_i,
  output emit_t                     emit_o
);

  mode_e                  mode_q, mode_d;
  kw_e                    kw_q, kw_d;
  logic [LINE_BITS-1:0]   line_q, line_d;
  logic [COLUMN_BITS-1:0] col_q, col_d;
  logic [LINE_BITS-1:0]   tok_line_q, tok_line_d;
  logic [COLUMN_BITS-1:0] tok_col_q, tok_col_d;
  logic [LENGTH_BITS-1:0] lex_q, lex_d;

  logic                   letter, digit, pending, have_flush, have_tail;
  record_t                flush_rec, tail_rec;
  logic [COLUMN_BITS-1:0] col_inc;
  logic [LENGTH_BITS-1:0] lex_inc;
  logic [LINE_BITS-1:0]   line_inc;

  always_comb begin
    letter   = is_letter(source_byte_i);
    digit    = is_digit(source_byte_i);
    pending  = (mode_q == MODE_IDENT) || (mode_q == MODE_NUM);
    col_inc  = (col_q == '1) ? col_q : col_q + 1'b1;
    lex_inc  = (lex_q == '1) ? lex_q : lex_q + 1'b1;
    line_inc = (line_q == '1) ? line_q : line_q + 1'b1;

    flush_rec        = '0;
    flush_rec.kind   = KIND_NUM;
    if (mode_q == MODE_IDENT) begin
      if (kw_q == KW_LET) begin
        flush_rec.kind = KIND_LET;
      end else if (kw_q == KW_FN) begin
        flush_rec.kind = KIND_FN;
      end else begin
        flush_rec.kind = KIND_IDENT;
      end
    end
    flush_rec.line   = tok_line_q;
    flush_rec.column = tok_col_q;
    flush_rec.length = lex_q;

    tail_rec        = '0;
    tail_rec.kind   = KIND_END;
    tail_rec.line   = line_q;
    tail_rec.column = col_q;
    have_flush      = 1'b0;
    have_tail       = 1'b0;

    mode_d     = mode_q;
    kw_d       = kw_q;
    line_d     = line_q;
    col_d      = col_q;
    tok_line_d = tok_line_q;
    tok_col_d  = tok_col_q;
    lex_d      = lex_q;

    if (!accept_i) begin
      have_flush = 1'b0;
    end else if (action_i) begin
      have_flush = pending;
      have_tail  = 1'b1;
      mode_d     = MODE_IDLE;
      kw_d       = KW_NONE;
      line_d     = LINE_BITS'(1);
      col_d      = COLUMN_BITS'(1);
      tok_line_d = LINE_BITS'(1);
      tok_col_d  = COLUMN_BITS'(1);
      lex_d      = '0;
    end else if (mode_q == MODE_HALT) begin
      have_flush = 1'b0;
    end else if ((mode_q == MODE_IDENT) && (letter || digit)) begin
      lex_d = lex_inc;
      kw_d  = next_progress(kw_q, source_byte_i);
      col_d = col_inc;
    end else if ((mode_q == MODE_NUM) && digit) begin
      lex_d = lex_inc;
      col_d = col_inc;
    end else begin
      if (pending) begin
        have_flush = 1'b1;
        mode_d     = MODE_IDLE;
        lex_d      = '0;
        kw_d       = KW_NONE;
      end
      if (source_byte_i == CHAR_SPACE) begin
        col_d = col_inc;
      end else if (source_byte_i == CHAR_NEWLINE) begin
        line_d = line_inc;
        col_d  = COLUMN_BITS'(1);
      end else if (letter || digit) begin
        mode_d     = letter ? MODE_IDENT : MODE_NUM;
        tok_line_d = line_q;
        tok_col_d  = col_q;
        lex_d      = LENGTH_BITS'(1);
        kw_d       = letter ? next_progress(KW_NONE, source_byte_i) : KW_NONE;
        col_d      = col_inc;
      end else if ((source_byte_i == CHAR_EQUALS) || (source_byte_i == CHAR_SEMI)) begin
        have_tail       = 1'b1;
        tail_rec.kind   = (source_byte_i == CHAR_EQUALS) ? KIND_EQ : KIND_SEMI;
        tail_rec.length = LENGTH_BITS'(1);
        col_d           = col_inc;
      end else begin
        have_tail       = 1'b1;
        tail_rec.kind   = KIND_STRAY;
        tail_rec.length = LENGTH_BITS'(1);
        tail_rec.stray  = source_byte_i;
        mode_d          = MODE_HALT;
      end
    end

    emit_o = '0;
    if (have_flush && have_tail) begin
      emit_o.num         = 2'd2;
      emit_o.first       = flush_rec;
      emit_o.second      = tail_rec;
      emit_o.second.last = 1'b1;
    end else if (have_flush) begin
      emit_o.num        = 2'd1;
      emit_o.first      = flush_rec;
      emit_o.first.last = 1'b1;
    end else if (have_tail) begin
      emit_o.num        = 2'd1;
      emit_o.first      = tail_rec;
      emit_o.first.last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_IDLE;
      kw_q       <= KW_NONE;
      line_q     <= LINE_BITS'(1);
      col_q      <= COLUMN_BITS'(1);
      tok_line_q <= LINE_BITS'(1);
      tok_col_q  <= COLUMN_BITS'(1);
      lex_q      <= '0;
    end else begin
      mode_q     <= mode_d;
      kw_q       <= kw_d;
      line_q     <= line_d;
      col_q      <= col_d;
      tok_line_q <= tok_line_d;
      tok_col_q  <= tok_col_d;
      lex_q      <= lex_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/source_byte_tokenizer.sv
// each record is registered into the record queue as its byte is accepted
// throughput: one byte per cycle while each byte yields at most one record and the
// receiver keeps up; a byte that yields two records (pending token plus terminator)
// writes both at once into the four-entry record queue
// reset: asynchronous active-low reset returns to idle at line 1, column 1, queue empty
`default_nettype none

module source_byte_tokenizer import sbt_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic                   action_i,
  input  wire logic [BYTE_BITS-1:0]   source_byte_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic [KIND_BITS-1:0]        token_kind_o,
  output logic [LINE_BITS-1:0]        start_line_o,
  output logic [COLUMN_BITS-1:0]      start_column_o,
  output logic [LENGTH_BITS-1:0]      token_length_o,
  output logic [BYTE_BITS-1:0]        stray_byte_o,
  output logic                        last_of_run_o
);

  emit_t               emit;
  logic                accept, pop;
  record_t             mem_q [FIFO_DEPTH];
  record_t             head;
  logic [PTR_BITS-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_BITS-1:0] count_q, count_d;

  assign in_ready_o = (count_q <= CNT_BITS'(FIFO_DEPTH - 2));
  assign accept     = in_valid_i && in_ready_o;

  sbt_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .action_i      (action_i),
    .source_byte_i (source_byte_i),
    .emit_o        (emit)
  );

  assign out_valid_o = (count_q != '0);
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    head           = mem_q[rd_ptr_q];
    token_kind_o   = head.kind;
    start_line_o   = head.line;
    start_column_o = head.column;
    token_length_o = head.length;
    stray_byte_o   = head.stray;
    last_of_run_o  = head.last;

    wr_ptr_d = PTR_BITS'(wr_ptr_q + PTR_BITS'(emit.num));
    rd_ptr_d = pop ? PTR_BITS'(rd_ptr_q + 1'b1) : rd_ptr_q;
    count_d  = CNT_BITS'(count_q + CNT_BITS'(emit.num) - CNT_BITS'(pop));
  end

  always_ff @(posedge clk_i) begin
    if (emit.num != 2'd0) begin
      mem_q[wr_ptr_q] <= emit.first;
    end
    if (emit.num == 2'd2) begin
      mem_q[PTR_BITS'(wr_ptr_q + 1'b1)] <= emit.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_BITS'(FIFO_DEPTH))
    else $error("record queue overfilled");

  a_end_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && action_i) |=> out_valid_o)
    else $error("end marker produced no record");

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (token_kind_o == KIND_END)) |-> last_of_run_o)
    else $error("end record not marked last");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    PTR_BITS'(wr_ptr_q - rd_ptr_q) == PTR_BITS'(count_q))
    else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

>>> sim/token_stream_checker.sv
module token_stream_checker
  import sbt_pkg::*;
#(
  parameter logic END_MARK = 1'b1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_ready_i,
  input  logic                   action_i,
  input  logic [BYTE_BITS-1:0]   source_byte_i,
  input  logic                   out_valid_i,
  input  logic                   out_ready_i,
  input  logic [KIND_BITS-1:0]   token_kind_i,
  input  logic [LINE_BITS-1:0]   start_line_i,
  input  logic [COLUMN_BITS-1:0] start_column_i,
  input  logic [LENGTH_BITS-1:0] token_length_i,
  input  logic [BYTE_BITS-1:0]   stray_byte_i,
  input  logic                   last_of_run_i,
  output int unsigned            mismatch_count_o,
  output int unsigned            pending_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PRINT_LIMIT = 40;

  mode_e                  scan_state;
  kw_e                    kw_state;
  logic [LINE_BITS-1:0]   cur_line;
  logic [COLUMN_BITS-1:0] cur_col;
  logic [LINE_BITS-1:0]   tok_line;
  logic [COLUMN_BITS-1:0] tok_col;
  logic [LENGTH_BITS-1:0] tok_len;
  record_t                expected_tokens[$];
  record_t                staged_tokens[$];
  int unsigned            token_index;

  function automatic longint unsigned sat_bump(input longint unsigned v,
                                               input int unsigned bits);
    longint unsigned ceiling;
    ceiling = (64'd1 << bits) - 64'd1;
    return (v >= ceiling) ? ceiling : v + 64'd1;
  endfunction

  function automatic bit alpha_byte(input logic [BYTE_BITS-1:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic bit numeral_byte(input logic [BYTE_BITS-1:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic kw_e advance_keyword(input kw_e from, input logic [BYTE_BITS-1:0] b);
    case (from)
      KW_NONE: return (b == CHAR_L) ? KW_L : ((b == CHAR_F) ? KW_F : KW_MISS);
      KW_L:    return (b == CHAR_E) ? KW_LE : KW_MISS;
      KW_LE:   return (b == CHAR_T) ? KW_LET : KW_MISS;
      KW_F:    return (b == CHAR_N) ? KW_FN : KW_MISS;
      default: return KW_MISS;
    endcase
  endfunction

  task automatic reset_scanner();
    scan_state = MODE_IDLE;
    kw_state   = KW_NONE;
    cur_line   = LINE_BITS'(1);
    cur_col    = COLUMN_BITS'(1);
    tok_line   = LINE_BITS'(1);
    tok_col    = COLUMN_BITS'(1);
    tok_len    = '0;
  endtask

  task automatic stage_token(input kind_e kind, input logic [LINE_BITS-1:0] ln,
                             input logic [COLUMN_BITS-1:0] cl,
                             input logic [LENGTH_BITS-1:0] len,
                             input logic [BYTE_BITS-1:0] sb);
    record_t rec;
    rec.kind   = kind;
    rec.line   = ln;
    rec.column = cl;
    rec.length = len;
    rec.stray  = sb;
    rec.last   = 1'b0;
    staged_tokens.push_back(rec);
  endtask

  task automatic flush_token();
    kind_e kind;
    if (scan_state == MODE_IDENT) begin
      kind = KIND_IDENT;
      if (kw_state == KW_LET) begin
        kind = KIND_LET;
      end else if (kw_state == KW_FN) begin
        kind = KIND_FN;
      end
    end else if (scan_state == MODE_NUM) begin
      kind = KIND_NUM;
    end else begin
      return;
    end
    stage_token(kind, tok_line, tok_col, tok_len, '0);
    scan_state = MODE_IDLE;
    tok_len    = '0;
    kw_state   = KW_NONE;
  endtask

  task automatic begin_token(input mode_e m, input logic [BYTE_BITS-1:0] b);
    scan_state = m;
    tok_line   = cur_line;
    tok_col    = cur_col;
    tok_len    = LENGTH_BITS'(1);
    kw_state   = (m == MODE_IDENT) ? advance_keyword(KW_NONE, b) : KW_NONE;
    cur_col    = COLUMN_BITS'(sat_bump(cur_col, COLUMN_BITS));
  endtask

  task automatic predict_tokens(input bit at_end, input logic [BYTE_BITS-1:0] b);
    record_t rec;
    staged_tokens.delete();
    if (at_end) begin
      flush_token();
      stage_token(KIND_END, cur_line, cur_col, '0, '0);
      reset_scanner();
    end else if (scan_state == MODE_HALT) begin
      // ignored until end of source
    end else if (scan_state == MODE_IDENT && (alpha_byte(b) || numeral_byte(b))) begin
      tok_len  = LENGTH_BITS'(sat_bump(tok_len, LENGTH_BITS));
      kw_state = advance_keyword(kw_state, b);
      cur_col  = COLUMN_BITS'(sat_bump(cur_col, COLUMN_BITS));
    end else if (scan_state == MODE_NUM && numeral_byte(b)) begin
      tok_len = LENGTH_BITS'(sat_bump(tok_len, LENGTH_BITS));
      cur_col = COLUMN_BITS'(sat_bump(cur_col, COLUMN_BITS));
    end else begin
      flush_token();
      if (b == CHAR_SPACE) begin
        cur_col = COLUMN_BITS'(sat_bump(cur_col, COLUMN_BITS));
      end else if (b == CHAR_NEWLINE) begin
        cur_line = LINE_BITS'(sat_bump(cur_line, LINE_BITS));
        cur_col  = COLUMN_BITS'(1);
      end else if (alpha_byte(b)) begin
        begin_token(MODE_IDENT, b);
      end else if (numeral_byte(b)) begin
        begin_token(MODE_NUM, b);
      end else if (b == CHAR_EQUALS || b == CHAR_SEMI) begin
        stage_token((b == CHAR_EQUALS) ? KIND_EQ : KIND_SEMI, cur_line, cur_col,
                    LENGTH_BITS'(1), '0);
        cur_col = COLUMN_BITS'(sat_bump(cur_col, COLUMN_BITS));
      end else begin
        stage_token(KIND_STRAY, cur_line, cur_col, LENGTH_BITS'(1), b);
        scan_state = MODE_HALT;
      end
    end
    for (int i = 0; i < staged_tokens.size(); i++) begin
      rec      = staged_tokens[i];
      rec.last = (i == staged_tokens.size() - 1);
      expected_tokens.push_back(rec);
    end
  endtask

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    if (mismatch_count_o < PRINT_LIMIT) begin
      $display("[%0t] token %0d %s: got %0h expected %0h", $realtime, token_index, what,
               got, want);
    end
    mismatch_count_o++;
  endtask

  task automatic check_token();
    record_t want;
    if (expected_tokens.size() == 0) begin
      report_mismatch("unexpected token, kind", token_kind_i, 0);
    end else begin
      want = expected_tokens.pop_front();
      if (token_kind_i !== want.kind) report_mismatch("kind", token_kind_i, want.kind);
      if (start_line_i !== want.line) report_mismatch("line", start_line_i, want.line);
      if (start_column_i !== want.column) begin
        report_mismatch("column", start_column_i, want.column);
      end
      if (token_length_i !== want.length) begin
        report_mismatch("length", token_length_i, want.length);
      end
      if (stray_byte_i !== want.stray) report_mismatch("stray", stray_byte_i, want.stray);
      if (last_of_run_i !== want.last) report_mismatch("last", last_of_run_i, want.last);
    end
    token_index++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_scanner();
      expected_tokens.delete();
      mismatch_count_o = 0;
      token_index      = 0;
    end else begin
      if (out_valid_i && out_ready_i) check_token();
      if (in_valid_i && in_ready_i) predict_tokens(action_i == END_MARK, source_byte_i);
    end
    pending_count_o = expected_tokens.size();
  end

endmodule

>>> sim/tb_source_byte_tokenizer.sv
module tb_source_byte_tokenizer;
  import sbt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic        ACT_BYTE       = 1'b0;
  localparam logic        ACT_END        = 1'b1;
  localparam int unsigned RANDOM_ITEMS   = 1100;
  localparam int unsigned DRAIN_EVERY    = 250;
  localparam int unsigned SETTLE_CYCLES  = 20;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   in_valid_i    = 1'b0;
  logic                   in_ready_o;
  logic                   action_i      = 1'b0;
  logic [BYTE_BITS-1:0]   source_byte_i = '0;
  logic                   out_valid_o;
  logic                   out_ready_i   = 1'b0;
  logic [KIND_BITS-1:0]   token_kind_o;
  logic [LINE_BITS-1:0]   start_line_o;
  logic [COLUMN_BITS-1:0] start_column_o;
  logic [LENGTH_BITS-1:0] token_length_o;
  logic [BYTE_BITS-1:0]   stray_byte_o;
  logic                   last_of_run_o;

  int unsigned mismatch_count;
  int unsigned pending_count;
  int unsigned live_items;
  int unsigned calm_left;
  int unsigned stall_left;
  int unsigned steady_left;
  int unsigned idle_cycles;
  bit          halted;

  string word_list[12] = '{"let", "fn", "le", "lets", "f", "fnx", "l", "fn2", "lett",
                           "LET", "Fn", "let0"};

  source_byte_tokenizer u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .action_i       (action_i),
    .source_byte_i  (source_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .token_kind_o   (token_kind_o),
    .start_line_o   (start_line_o),
    .start_column_o (start_column_o),
    .token_length_o (token_length_o),
    .stray_byte_o   (stray_byte_o),
    .last_of_run_o  (last_of_run_o)
  );

  token_stream_checker #(
    .END_MARK (ACT_END)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .action_i         (action_i),
    .source_byte_i    (source_byte_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .token_kind_i     (token_kind_o),
    .start_line_i     (start_line_o),
    .start_column_i   (start_column_o),
    .token_length_i   (token_length_o),
    .stray_byte_i     (stray_byte_o),
    .last_of_run_i    (last_of_run_o),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver back-pressure: calm stretches, short stalls, rare long stalls
  always @(negedge clk_i) begin : out_ready_gen
    int unsigned r;
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else if (steady_left > 0) begin
      out_ready_i <= 1'b1;
      steady_left--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 5) begin
        steady_left = $urandom_range(20, 100);
        out_ready_i <= 1'b1;
      end else if (r < 70) begin
        out_ready_i <= 1'b1;
      end else if (r < 95) begin
        stall_left = $urandom_range(0, 2);
        out_ready_i <= 1'b0;
      end else begin
        stall_left = $urandom_range(5, 40);
        out_ready_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("no transaction for %0d cycles", idle_cycles);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) calm_left = $urandom_range(20, 80);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic [BYTE_BITS-1:0] random_letter();
    int unsigned r;
    r = $urandom_range(0, 51);
    return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
  endfunction

  function automatic logic [BYTE_BITS-1:0] random_digit();
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  function automatic logic [BYTE_BITS-1:0] random_stray();
    logic [BYTE_BITS-1:0] picks[5];
    picks = '{8'h3A, 8'h3C, 8'h3E, 8'h3F, 8'h40};
    case ($urandom_range(0, 6))
      0:       return 8'($urandom_range(0, 9));
      1:       return 8'($urandom_range(11, 31));
      2:       return 8'($urandom_range(33, 47));
      3:       return picks[$urandom_range(0, 4)];
      4:       return 8'($urandom_range(91, 96));
      default: return 8'($urandom_range(123, 255));
    endcase
  endfunction

  task automatic send_item(input logic act, input logic [BYTE_BITS-1:0] b);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    action_i      <= act;
    source_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    if (act == ACT_END) begin
      halted = 1'b0;
    end else if (!halted) begin
      live_items++;
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(ACT_BYTE, s[i]);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
  endtask

  initial begin
    int unsigned pick;
    int unsigned n;
    int unsigned next_drain;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // keywords, adjacent tokens, stray tab, halt, end with pending token
    send_text("let a=0;\n");
    send_text("fn Zz9=19");
    send_item(ACT_BYTE, 8'h09);
    send_item(ACT_END, 8'hFF);
    send_text("A9");
    send_item(ACT_END, 8'h00);
    send_item(ACT_BYTE, "7");
    send_item(ACT_BYTE, 8'hFF);
    send_item(ACT_BYTE, "q");
    send_item(ACT_END, 8'h5A);
    drain();

    // saturation of the length counter
    send_item(ACT_BYTE, CHAR_L);
    repeat (299) send_item(ACT_BYTE, $urandom_range(0, 3) == 0 ? random_digit() : random_letter());
    send_item(ACT_BYTE, CHAR_SEMI);
    send_item(ACT_END, 8'h00);
    send_text("x=");
    send_item(ACT_END, 8'h00);
    send_text("7;");
    send_item(ACT_END, 8'h00);
    drain();

    live_items = 0;
    next_drain = DRAIN_EVERY;
    while (live_items < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        if ($urandom_range(0, 2) == 0) begin
          send_text(word_list[$urandom_range(0, 11)]);
        end else begin
          n = $urandom_range(1, 8);
          send_item(ACT_BYTE, random_letter());
          repeat (n - 1) begin
            send_item(ACT_BYTE, $urandom_range(0, 3) == 0 ? random_digit() : random_letter());
          end
        end
      end else if (pick < 48) begin
        repeat ($urandom_range(1, 6)) send_item(ACT_BYTE, random_digit());
      end else if (pick < 58) begin
        send_item(ACT_BYTE, CHAR_EQUALS);
      end else if (pick < 68) begin
        send_item(ACT_BYTE, CHAR_SEMI);
      end else if (pick < 80) begin
        repeat ($urandom_range(1, 3)) send_item(ACT_BYTE, CHAR_SPACE);
      end else if (pick < 87) begin
        send_item(ACT_BYTE, CHAR_NEWLINE);
      end else if (pick < 91) begin
        send_item(ACT_END, 8'($urandom_range(0, 255)));
      end else if (pick < 95) begin
        send_item(ACT_BYTE, random_stray());
        halted = 1'b1;
        repeat ($urandom_range(0, 4)) send_item(ACT_BYTE, 8'($urandom_range(0, 255)));
        send_item(ACT_END, 8'($urandom_range(0, 255)));
      end else begin
        send_item(ACT_BYTE, 8'($urandom_range(0, 255)));
      end
      if (live_items >= next_drain) begin
        drain();
        next_drain += DRAIN_EVERY;
      end
    end
    send_item(ACT_END, 8'h00);

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    if (pending_count != 0) $display("%0d expected tokens never arrived", pending_count);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
